@@ sv/iufp_pkg.sv @@
// ----------------------------------------------------------------------------
// iufp_pkg
// Shared types, frame layout and fixed-point scaling constants for the IMU
// serial frame parser.
// ----------------------------------------------------------------------------
package iufp_pkg;

  // frame layout, positions counted from the first byte after the header
  localparam int FRAME_LEN = 56;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  localparam int CMD_POS   = 0;
  localparam int TAIL1_POS = 54;
  localparam int TAIL2_POS = 55;

  localparam int RATE_PITCH_POS = 14;
  localparam int RATE_ROLL_POS  = 16;
  localparam int RATE_YAW_POS   = 18;
  localparam int ROLL_POS       = 32;
  localparam int PITCH_POS      = 36;
  localparam int YAW_POS        = 40;
  localparam int QUAT_W_POS     = 44;
  localparam int QUAT_X_POS     = 46;
  localparam int QUAT_Y_POS     = 48;
  localparam int QUAT_Z_POS     = 50;

  localparam int HIST_DEPTH = 3;

  localparam logic [7:0] HEADER_BYTE = 8'hA5;
  localparam logic [7:0] TAIL1_BYTE  = 8'h5A;
  localparam logic [7:0] TAIL2_BYTE  = 8'hA5;

  localparam int ERR_W = 5;
  localparam logic [ERR_W-1:0] REJECT_WRAP = 5'd20;

  // rate: mag * 45056 / 25, quotient by reciprocal 2^36 / 25
  localparam logic [15:0] RATE_NUM   = 16'd45056;
  localparam logic [30:0] RATE_HALF  = 31'd12;
  localparam logic [31:0] RATE_RECIP = 32'd2748779070;
  localparam int          RATE_SHIFT = 36;

  // quaternion: mag * 4096 / 625, quotient by reciprocal 2^41 / 625
  localparam int          QUAT_NUM_SHIFT = 12;
  localparam logic [30:0] QUAT_HALF      = 31'd312;
  localparam logic [31:0] QUAT_RECIP     = 32'd3518437209;
  localparam int          QUAT_SHIFT     = 41;

  // angle: mag * 2^22 / 5625 = 745 * mag + (3679 * mag + 2812) / 5625
  localparam logic [31:0] ANG_SAT_MAG = 32'd2880000;
  localparam logic [9:0]  ANG_WHOLE   = 10'd745;
  localparam logic [11:0] ANG_FRAC    = 12'd3679;
  localparam logic [33:0] ANG_HALF    = 34'd2812;
  localparam logic [32:0] ANG_RECIP   = 33'd6254999483;
  localparam int          ANG_SPLIT   = 17;
  localparam int          ANG_SHIFT   = 45;

  localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q16_MIN = 32'h8000_0000;

  typedef logic signed [31:0] q16_t;

  typedef enum logic {
    ST_HUNT,
    ST_FRAME
  } parse_state_t;

  typedef enum logic [2:0] {
    SF_RATE_PITCH,
    SF_RATE_ROLL,
    SF_RATE_YAW,
    SF_QUAT_W,
    SF_QUAT_X,
    SF_QUAT_Y,
    SF_QUAT_Z
  } small_field_t;

  typedef enum logic [1:0] {
    AF_ROLL,
    AF_PITCH,
    AF_YAW
  } angle_field_t;

  typedef struct packed {
    logic               valid;
    small_field_t       field;
    logic signed [15:0] raw;
  } small_issue_t;

  typedef struct packed {
    logic               valid;
    angle_field_t       field;
    logic signed [31:0] raw;
  } angle_issue_t;

  typedef struct packed {
    logic             last_pending;
    logic             done;
    logic             good;
    logic [ERR_W-1:0] err_cnt;
  } frame_status_t;

  typedef struct packed {
    q16_t rate_pitch;
    q16_t rate_roll;
    q16_t rate_yaw;
    q16_t quat_w;
    q16_t quat_x;
    q16_t quat_y;
    q16_t quat_z;
  } small_result_t;

  typedef struct packed {
    q16_t roll;
    q16_t pitch;
    q16_t yaw;
  } angle_result_t;

endpackage

@@ sv/iufp_frame_tracker.sv @@
// ----------------------------------------------------------------------------
// iufp_frame_tracker
// Header hunt, byte position, check bytes and reject counter; issues each
// data field to its scaler as soon as its last byte arrives.
// ----------------------------------------------------------------------------
module iufp_frame_tracker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_accept,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             expected_cmd,
  output iufp_pkg::frame_status_t status,
  output iufp_pkg::small_issue_t  small_issue,
  output iufp_pkg::angle_issue_t  angle_issue
);
  import iufp_pkg::*;

  parse_state_t     state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [ERR_W-1:0] rej_r, rej_nxt;
  logic [7:0]       hist_r [HIST_DEPTH];
  logic [7:0]       cmd_r, tail1_r, tail2_r;
  logic [7:0]       cmd_chk, tail1_chk, tail2_chk;
  logic             byte_take;
  logic             done;
  logic             good;
  small_issue_t     small_r, small_nxt;
  angle_issue_t     angle_r, angle_nxt;

  assign byte_take = byte_accept && (state_r == ST_FRAME);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      idx_r   <= '0;
      rej_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      rej_r   <= rej_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    done      = 1'b0;
    case (state_r)
      ST_HUNT: begin
        if (byte_accept && rx_byte == HEADER_BYTE) begin
          state_nxt = ST_FRAME;
          idx_nxt   = '0;
        end
      end
      ST_FRAME: begin
        if (byte_accept) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_HUNT;
            idx_nxt   = '0;
            done      = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
        idx_nxt   = '0;
      end
    endcase
  end

  // check bytes, the one in the last position comes straight from the input
  assign cmd_chk   = (IDX_W'(CMD_POS) == LAST_IDX) ? rx_byte : cmd_r;
  assign tail1_chk = (IDX_W'(TAIL1_POS) == LAST_IDX) ? rx_byte : tail1_r;
  assign tail2_chk = (IDX_W'(TAIL2_POS) == LAST_IDX) ? rx_byte : tail2_r;
  assign good = (cmd_chk == expected_cmd) && (tail1_chk == TAIL1_BYTE) &&
                (tail2_chk == TAIL2_BYTE);

  always_comb begin
    rej_nxt = rej_r;
    if (done && !good) begin
      rej_nxt = (rej_r == REJECT_WRAP - 5'd1) ? '0 : rej_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      hist_r[0] <= rx_byte;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
      if (idx_r == IDX_W'(CMD_POS)) begin
        cmd_r <= rx_byte;
      end
      if (idx_r == IDX_W'(TAIL1_POS)) begin
        tail1_r <= rx_byte;
      end
      if (idx_r == IDX_W'(TAIL2_POS)) begin
        tail2_r <= rx_byte;
      end
    end
  end

  // little endian: the byte arriving now is the most significant one
  always_comb begin
    small_nxt.valid = 1'b0;
    small_nxt.field = SF_RATE_PITCH;
    small_nxt.raw   = {rx_byte, hist_r[0]};
    if (byte_take) begin
      case (idx_r)
        IDX_W'(RATE_PITCH_POS + 1): begin
          small_nxt.valid = 1'b1;
          small_nxt.field = SF_RATE_PITCH;
        end
        IDX_W'(RATE_ROLL_POS + 1): begin
          small_nxt.valid = 1'b1;
          small_nxt.field = SF_RATE_ROLL;
        end
        IDX_W'(RATE_YAW_POS + 1): begin
          small_nxt.valid = 1'b1;
          small_nxt.field = SF_RATE_YAW;
        end
        IDX_W'(QUAT_W_POS + 1): begin
          small_nxt.valid = 1'b1;
          small_nxt.field = SF_QUAT_W;
        end
        IDX_W'(QUAT_X_POS + 1): begin
          small_nxt.valid = 1'b1;
          small_nxt.field = SF_QUAT_X;
        end
        IDX_W'(QUAT_Y_POS + 1): begin
          small_nxt.valid = 1'b1;
          small_nxt.field = SF_QUAT_Y;
        end
        IDX_W'(QUAT_Z_POS + 1): begin
          small_nxt.valid = 1'b1;
          small_nxt.field = SF_QUAT_Z;
        end
        default: small_nxt.valid = 1'b0;
      endcase
    end
  end

  always_comb begin
    angle_nxt.valid = 1'b0;
    angle_nxt.field = AF_ROLL;
    angle_nxt.raw   = {rx_byte, hist_r[0], hist_r[1], hist_r[2]};
    if (byte_take) begin
      case (idx_r)
        IDX_W'(ROLL_POS + 3): begin
          angle_nxt.valid = 1'b1;
          angle_nxt.field = AF_ROLL;
        end
        IDX_W'(PITCH_POS + 3): begin
          angle_nxt.valid = 1'b1;
          angle_nxt.field = AF_PITCH;
        end
        IDX_W'(YAW_POS + 3): begin
          angle_nxt.valid = 1'b1;
          angle_nxt.field = AF_YAW;
        end
        default: angle_nxt.valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_r.valid <= 1'b0;
      angle_r.valid <= 1'b0;
    end else begin
      small_r <= small_nxt;
      angle_r <= angle_nxt;
    end
  end

  assign small_issue = small_r;
  assign angle_issue = angle_r;

  assign status.last_pending = (state_r == ST_FRAME) && (idx_r == LAST_IDX);
  assign status.done         = done;
  assign status.good         = good;
  assign status.err_cnt      = rej_nxt;

endmodule

@@ sv/iufp_small_scaler.sv @@
// ----------------------------------------------------------------------------
// iufp_small_scaler
// Three-stage pipeline scaling 16-bit rate and quaternion fields to Q16.16
// with round half away from zero; holds the latest value of each field.
// ----------------------------------------------------------------------------
module iufp_small_scaler (
  input  logic                    clk,
  input  logic                    rst_n,
  input  iufp_pkg::small_issue_t  issue,
  output iufp_pkg::small_result_t result
);
  import iufp_pkg::*;

  logic          in_rate;
  logic          in_neg;
  logic [15:0]   raw_u;
  logic [15:0]   mag;
  logic [30:0]   mag_w;
  logic [30:0]   num;

  logic          s1_valid_r;
  small_field_t  s1_field_r;
  logic          s1_rate_r;
  logic          s1_neg_r;
  logic [30:0]   s1_num_r;

  logic          s2_valid_r;
  small_field_t  s2_field_r;
  logic          s2_rate_r;
  logic          s2_neg_r;
  logic [62:0]   s2_prod_r;
  logic [62:0]   prod;

  logic [62:0]   shifted;
  logic [31:0]   q;
  logic [31:0]   res;
  small_result_t hold_r;

  assign in_rate = (issue.field == SF_RATE_PITCH) || (issue.field == SF_RATE_ROLL) ||
                   (issue.field == SF_RATE_YAW);
  assign raw_u   = issue.raw;
  assign in_neg  = raw_u[15];
  assign mag     = in_neg ? (~raw_u + 16'd1) : raw_u;
  assign mag_w   = 31'(mag);
  assign num     = in_rate ? (mag_w * 31'(RATE_NUM)) + RATE_HALF
                           : (mag_w << QUAT_NUM_SHIFT) + QUAT_HALF;

  // stage 1: numerator plus half divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue.valid;
    end
    s1_field_r <= issue.field;
    s1_rate_r  <= in_rate;
    s1_neg_r   <= in_neg;
    s1_num_r   <= num;
  end

  // stage 2: multiply by the divisor reciprocal
  assign prod = 63'(s1_num_r) * 63'(s1_rate_r ? RATE_RECIP : QUAT_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_field_r <= s1_field_r;
    s2_rate_r  <= s1_rate_r;
    s2_neg_r   <= s1_neg_r;
    s2_prod_r  <= prod;
  end

  // stage 3: quotient, sign, write to the field's hold register
  assign shifted = s2_rate_r ? (s2_prod_r >> RATE_SHIFT) : (s2_prod_r >> QUAT_SHIFT);
  assign q       = shifted[31:0];
  assign res     = s2_neg_r ? (~q + 32'd1) : q;

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      case (s2_field_r)
        SF_RATE_PITCH: hold_r.rate_pitch <= res;
        SF_RATE_ROLL:  hold_r.rate_roll  <= res;
        SF_RATE_YAW:   hold_r.rate_yaw   <= res;
        SF_QUAT_W:     hold_r.quat_w     <= res;
        SF_QUAT_X:     hold_r.quat_x     <= res;
        SF_QUAT_Y:     hold_r.quat_y     <= res;
        SF_QUAT_Z:     hold_r.quat_z     <= res;
        default:       hold_r            <= hold_r;
      endcase
    end
  end

  assign result = hold_r;

endmodule

@@ sv/iufp_angle_scaler.sv @@
// ----------------------------------------------------------------------------
// iufp_angle_scaler
// Four-stage pipeline dividing 32-bit angle fields by 87.890625 into Q16.16
// with round half away from zero and saturation; holds the latest values.
// ----------------------------------------------------------------------------
module iufp_angle_scaler (
  input  logic                    clk,
  input  logic                    rst_n,
  input  iufp_pkg::angle_issue_t  issue,
  output iufp_pkg::angle_result_t result
);
  import iufp_pkg::*;

  logic [31:0]   raw_u;
  logic          in_neg;
  logic [31:0]   mag;
  logic [21:0]   mag22;

  logic          a_valid_r;
  angle_field_t  a_field_r;
  logic          a_neg_r;
  logic          a_sat_r;
  logic [30:0]   a_whole_r;
  logic [33:0]   a_frac_r;

  logic          b_valid_r;
  angle_field_t  b_field_r;
  logic          b_neg_r;
  logic          b_sat_r;
  logic [30:0]   b_whole_r;
  logic [49:0]   b_ph_r;
  logic [49:0]   b_pl_r;

  logic          c_valid_r;
  angle_field_t  c_field_r;
  logic          c_neg_r;
  logic          c_sat_r;
  logic [30:0]   c_whole_r;
  logic [21:0]   c_qlo_r;
  logic [66:0]   sum;

  logic [30:0]   q;
  logic [31:0]   q_w;
  logic [31:0]   res;
  angle_result_t hold_r;

  assign raw_u  = issue.raw;
  assign in_neg = raw_u[31];
  assign mag    = in_neg ? (~raw_u + 32'd1) : raw_u;
  assign mag22  = mag[21:0];

  // stage a: whole part and remainder numerator, below the saturation point
  // the magnitude fits 22 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= issue.valid;
    end
    a_field_r <= issue.field;
    a_neg_r   <= in_neg;
    a_sat_r   <= (mag >= ANG_SAT_MAG);
    a_whole_r <= 31'(mag22) * 31'(ANG_WHOLE);
    a_frac_r  <= (34'(mag22) * 34'(ANG_FRAC)) + ANG_HALF;
  end

  // stage b: reciprocal multiply in two partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    b_field_r <= a_field_r;
    b_neg_r   <= a_neg_r;
    b_sat_r   <= a_sat_r;
    b_whole_r <= a_whole_r;
    b_ph_r    <= 50'(a_frac_r[33:ANG_SPLIT]) * 50'(ANG_RECIP);
    b_pl_r    <= 50'(a_frac_r[ANG_SPLIT-1:0]) * 50'(ANG_RECIP);
  end

  // stage c: combine partial products, keep the quotient bits
  assign sum = {b_ph_r, {ANG_SPLIT{1'b0}}} + 67'(b_pl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
    c_field_r <= b_field_r;
    c_neg_r   <= b_neg_r;
    c_sat_r   <= b_sat_r;
    c_whole_r <= b_whole_r;
    c_qlo_r   <= sum[66:ANG_SHIFT];
  end

  // stage d: final quotient, sign and saturation
  assign q   = c_whole_r + 31'(c_qlo_r);
  assign q_w = 32'(q);
  always_comb begin
    if (c_sat_r) begin
      res = c_neg_r ? Q16_MIN : Q16_MAX;
    end else begin
      res = c_neg_r ? (~q_w + 32'd1) : q_w;
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid_r) begin
      case (c_field_r)
        AF_ROLL:  hold_r.roll  <= res;
        AF_PITCH: hold_r.pitch <= res;
        AF_YAW:   hold_r.yaw   <= res;
        default:  hold_r       <= hold_r;
      endcase
    end
  end

  assign result = hold_r;

endmodule

@@ sv/imu_uart_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// imu_uart_frame_parser_core
// Parses IMU serial frames and emits checked, scaled Q16.16 readings.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------
//   in      | in_valid / in_stall | in_rx_byte
//   out     | out_valid/out_stall | out_frame_good, out_error_count, 10 x Q16.16
//   cfg     | cfg_valid/cfg_ready | cfg_expected_command
//
// One byte is taken every unstalled cycle with in_valid high. A result is
// registered when the last frame byte is accepted. Each data field is scaled
// in a pipeline (three stages for 16-bit fields, four for angles) started
// when its last byte arrives, which finishes before the frame's last byte.
// in_stall rises only while the last frame byte is due and the output
// register holds a result not yet taken. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module imu_uart_frame_parser_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_frame_good,
  output logic [iufp_pkg::ERR_W-1:0] out_error_count,
  output iufp_pkg::q16_t            out_roll_deg,
  output iufp_pkg::q16_t            out_pitch_deg,
  output iufp_pkg::q16_t            out_yaw_deg,
  output iufp_pkg::q16_t            out_rate_pitch,
  output iufp_pkg::q16_t            out_rate_roll,
  output iufp_pkg::q16_t            out_rate_yaw,
  output iufp_pkg::q16_t            out_quat_w,
  output iufp_pkg::q16_t            out_quat_x,
  output iufp_pkg::q16_t            out_quat_y,
  output iufp_pkg::q16_t            out_quat_z,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_expected_command
);
  import iufp_pkg::*;

  logic          in_accept;
  logic [7:0]    exp_cmd_r;
  frame_status_t status;
  small_issue_t  small_issue;
  angle_issue_t  angle_issue;
  small_result_t small_res;
  angle_result_t angle_res;

  logic             out_valid_r, out_valid_nxt;
  logic             good_r;
  logic [ERR_W-1:0] err_r;
  small_result_t    small_out_r;
  angle_result_t    angle_out_r;

  assign in_stall  = out_valid_r && out_stall && status.last_pending;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cmd_r <= '0;
    end else if (cfg_valid) begin
      exp_cmd_r <= cfg_expected_command;
    end
  end

  iufp_frame_tracker u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_accept  (in_accept),
    .rx_byte      (in_rx_byte),
    .expected_cmd (exp_cmd_r),
    .status       (status),
    .small_issue  (small_issue),
    .angle_issue  (angle_issue)
  );

  iufp_small_scaler u_small (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (small_issue),
    .result (small_res)
  );

  iufp_angle_scaler u_angle (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (angle_issue),
    .result (angle_res)
  );

  assign out_valid_nxt = status.done ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // rejected frames report zero readings
  always_ff @(posedge clk) begin
    if (status.done) begin
      good_r      <= status.good;
      err_r       <= status.err_cnt;
      small_out_r <= status.good ? small_res : '0;
      angle_out_r <= status.good ? angle_res : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_good  = good_r;
  assign out_error_count = err_r;
  assign out_roll_deg    = angle_out_r.roll;
  assign out_pitch_deg   = angle_out_r.pitch;
  assign out_yaw_deg     = angle_out_r.yaw;
  assign out_rate_pitch  = small_out_r.rate_pitch;
  assign out_rate_roll   = small_out_r.rate_roll;
  assign out_rate_yaw    = small_out_r.rate_yaw;
  assign out_quat_w      = small_out_r.quat_w;
  assign out_quat_x      = small_out_r.quat_x;
  assign out_quat_y      = small_out_r.quat_y;
  assign out_quat_z      = small_out_r.quat_z;

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IMU serial frame parser core. Bytes go in as
// bursts with random gaps and the result side stalls in changing patterns.
// Headers, junk, command and tail checks and saturating Q16.16 scaling are
// covered, and each frame is checked field by field against a local model
// of the parser or, for typed directed frames, against the case table.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iufp_pkg::*;

  localparam int NUM_VALS     = 10;
  localparam int DRAIN_CYCLES = 8;

  // scale factors as exact fractions of Q16.16 steps
  localparam longint unsigned ANG_MUL  = 64'd4194304;
  localparam longint unsigned ANG_DIV  = 64'd5625;
  localparam longint unsigned GYRO_MUL = 64'd45056;
  localparam longint unsigned GYRO_DIV = 64'd25;
  localparam longint unsigned QTN_MUL  = 64'd4096;
  localparam longint unsigned QTN_DIV  = 64'd625;

  // val[0..2] angles, val[3..5] rates, val[6..9] quaternion
  typedef struct packed {
    logic                      good;
    logic [ERR_W-1:0]          errs;
    q16_t [NUM_VALS-1:0]       val;
  } imu_reading_t;

  typedef logic [FRAME_LEN-1:0][7:0] frame_body_t;

  typedef struct packed {
    logic [2:0]       junk_n;
    logic [7:0]       fill;
    logic [7:0]       cmd;
    logic [7:0]       tail1;
    logic [7:0]       tail2;
    logic [31:0]      ang;
    logic [15:0]      sml;
    logic             typed;
    logic             good;
    logic [ERR_W-1:0] errs;
    q16_t             ang_q;
    q16_t             sml_q;
  } frame_case_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_frame_good;
  logic [ERR_W-1:0] out_error_count;
  q16_t             out_roll_deg, out_pitch_deg, out_yaw_deg;
  q16_t             out_rate_pitch, out_rate_roll, out_rate_yaw;
  q16_t             out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [7:0]       cfg_expected_command = 8'h00;

  imu_uart_frame_parser_core DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // parser model state
  logic [7:0]       cmd_reg = 8'h00;
  logic             parse_open = 1'b0;
  int               fill_idx = 0;
  logic [7:0]       frame_img [128];
  logic [ERR_W-1:0] rejects = '0;

  imu_reading_t want_q [$];
  int           frames_closed = 0;
  int           mismatches = 0;
  int           burst_left = 0;
  int           stall_mode = 0;
  int           stall_left = 0;

  string val_name [NUM_VALS] = '{"roll_deg", "pitch_deg", "yaw_deg", "rate_pitch",
                                 "rate_roll", "rate_yaw", "quat_w", "quat_x",
                                 "quat_y", "quat_z"};
  logic [7:0]  junk_pat [8] = '{8'h00, 8'hFF, 8'h5A, 8'h55, 8'hAA, 8'hA4, 8'hA6, 8'h7F};
  logic [31:0] ang_edge [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                32'hFFFF_FFFF, 32'h002B_F200, 32'hFFD4_0E00};
  logic [15:0] sml_edge [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};

  //   junk fill   cmd    tail1  tail2  ang            sml       typed good errs ang_q sml_q
  frame_case_t dir_cases [14] = '{
    '{0, 8'h00, 8'h00, 8'h5A, 8'hA5, 32'h0000_0000, 16'h0000, 1, 1, 0, 32'h0, 32'h0},
    '{0, 8'h00, 8'h01, 8'h5A, 8'hA5, 32'h0000_0000, 16'h0000, 1, 0, 1, 32'h0, 32'h0},
    '{1, 8'h00, 8'h00, 8'h5B, 8'hA5, 32'h0000_0000, 16'h0000, 1, 0, 2, 32'h0, 32'h0},
    '{2, 8'h00, 8'h00, 8'h5A, 8'hA4, 32'h0000_0000, 16'h0000, 1, 0, 3, 32'h0, 32'h0},
    '{0, 8'h00, 8'h00, 8'h5A, 8'hA5, 32'h7FFF_FFFF, 16'h0000, 1, 1, 3, Q16_MAX, 32'h0},
    '{0, 8'h00, 8'h00, 8'h5A, 8'hA5, 32'h8000_0000, 16'h0000, 1, 1, 3, Q16_MIN, 32'h0},
    '{3, 8'h11, 8'h00, 8'h5A, 8'hA5, 32'h0000_0000, 16'h7FFF, 0, 0, 0, 32'h0, 32'h0},
    '{0, 8'hEE, 8'h00, 8'h5A, 8'hA5, 32'h0000_0000, 16'h8000, 0, 0, 0, 32'h0, 32'h0},
    '{7, 8'hA5, 8'h00, 8'h5A, 8'hA5, 32'h0000_0001, 16'h0001, 0, 0, 0, 32'h0, 32'h0},
    '{4, 8'hFF, 8'h00, 8'h5A, 8'hA5, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0, 32'h0, 32'h0},
    '{0, 8'h00, 8'h00, 8'h5A, 8'hA5, 32'h002B_F200, 16'h7FFE, 0, 0, 0, 32'h0, 32'h0},
    '{0, 8'h5A, 8'h00, 8'h5A, 8'hA5, 32'hFFD4_0E00, 16'h0001, 0, 0, 0, 32'h0, 32'h0},
    '{5, 8'h00, 8'h00, 8'h5A, 8'hA5, 32'h002B_F1FF, 16'h1234, 0, 0, 0, 32'h0, 32'h0},
    '{6, 8'h00, 8'h7E, 8'h00, 8'h00, 32'h0000_0000, 16'h0000, 1, 0, 4, 32'h0, 32'h0}
  };

  initial begin
    for (int k = 0; k < 128; k++) frame_img[k] = 8'h00;
  end

  function automatic int field_pos(int i);
    case (i)
      0: return ROLL_POS;
      1: return PITCH_POS;
      2: return YAW_POS;
      3: return RATE_PITCH_POS;
      4: return RATE_ROLL_POS;
      5: return RATE_YAW_POS;
      6: return QUAT_W_POS;
      7: return QUAT_X_POS;
      8: return QUAT_Y_POS;
      default: return QUAT_Z_POS;
    endcase
  endfunction

  // round to nearest, ties away from zero, then clamp to 32-bit signed
  function automatic q16_t scale_q16(longint raw, longint unsigned mul,
                                     longint unsigned div);
    longint unsigned mag, q;
    mag = (raw < 0) ? -raw : raw;
    q = (mag * mul + div / 2) / div;
    if (raw < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return q16_t'(~q[31:0] + 32'd1);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q16_t'(q[31:0]);
  endfunction

  function automatic longint raw_at(int pos, int nbytes);
    logic [31:0] u;
    u = '0;
    for (int k = nbytes - 1; k >= 0; k--) u = {u[23:0], frame_img[(pos + k) & 127]};
    return (nbytes == 2) ? longint'($signed(u[15:0])) : longint'($signed(u));
  endfunction

  // advance the parser model by one byte, returns 1 when a frame closes
  function automatic bit parse_byte(input logic [7:0] b, output imu_reading_t r);
    r = '0;
    if (!parse_open) begin
      if (b == HEADER_BYTE) begin
        parse_open = 1'b1;
        fill_idx = 0;
      end
      return 1'b0;
    end
    if (fill_idx < FRAME_LEN) begin
      frame_img[fill_idx & 127] = b;
      fill_idx++;
    end
    if (fill_idx < FRAME_LEN) return 1'b0;
    parse_open = 1'b0;
    fill_idx = 0;
    if (frame_img[CMD_POS & 127] == cmd_reg && frame_img[TAIL1_POS & 127] == TAIL1_BYTE &&
        frame_img[TAIL2_POS & 127] == TAIL2_BYTE) begin
      r.good = 1'b1;
      r.errs = rejects;
      for (int i = 0; i < NUM_VALS; i++) begin
        r.val[i] = scale_q16(raw_at(field_pos(i), (i < 3) ? 4 : 2),
                             (i < 3) ? ANG_MUL : (i < 6) ? GYRO_MUL : QTN_MUL,
                             (i < 3) ? ANG_DIV : (i < 6) ? GYRO_DIV : QTN_DIV);
      end
    end else begin
      rejects = (rejects == REJECT_WRAP - 5'd1) ? '0 : rejects + 1'b1;
      r.errs = rejects;
    end
    return 1'b1;
  endfunction

  function automatic frame_body_t build_body(logic [7:0] fill, bit rand_fill,
                                             logic [7:0] cmd, logic [7:0] t1,
                                             logic [7:0] t2, logic [2:0][31:0] ang,
                                             logic [6:0][15:0] sml);
    frame_body_t body;
    for (int k = 0; k < FRAME_LEN; k++) body[k] = rand_fill ? 8'($urandom_range(0, 255)) : fill;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 4; k++) body[field_pos(i) + k] = ang[i][8*k +: 8];
    for (int i = 3; i < NUM_VALS; i++)
      for (int k = 0; k < 2; k++) body[field_pos(i) + k] = sml[i-3][8*k +: 8];
    body[CMD_POS]   = cmd;
    body[TAIL1_POS] = t1;
    body[TAIL2_POS] = t2;
    return body;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // hold each request until the parser takes it, then maybe open a gap
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input imu_reading_t given = '0);
    imu_reading_t r;
    int gap;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (parse_byte(b, r)) begin
      want_q.push_back(typed ? given : r);
      frames_closed++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_frame(input frame_body_t body, input bit typed,
                            input imu_reading_t given);
    send_byte(HEADER_BYTE);
    for (int k = 0; k < FRAME_LEN; k++) send_byte(body[k], typed && k == FRAME_LEN - 1, given);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    // a header or data byte may still be in flight with no result behind it
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cmd(input logic [7:0] v);
    cfg_valid            <= 1'b1;
    cfg_expected_command <= v;
    do @(posedge clk); while (!cfg_ready);
    cmd_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] cmd);
    int               phase_bytes, base;
    logic [2:0][31:0] ang;
    logic [6:0][15:0] sml;
    logic [7:0]       c, t1, t2;
    write_cmd(cmd);
    phase_bytes = 0;
    base = frames_closed;
    while (phase_bytes < 150 || frames_closed - base < 3) begin
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      c  = cmd;
      t1 = TAIL1_BYTE;
      t2 = TAIL2_BYTE;
      if ($urandom_range(0, 4) == 0) c  = cmd ^ 8'($urandom_range(1, 255));
      if ($urandom_range(0, 4) == 0) t1 = t1 ^ 8'($urandom_range(1, 255));
      if ($urandom_range(0, 4) == 0) t2 = t2 ^ 8'($urandom_range(1, 255));
      // angles full range, in +-3000000 or +-1000, or edges like the +-2880000 knee
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 3))
          0: ang[i] = $urandom;
          1: ang[i] = 32'($urandom_range(0, 6_000_000)) - 32'd3_000_000;
          2: ang[i] = ang_edge[$urandom_range(0, 5)];
          default: ang[i] = 32'($urandom_range(0, 2000)) - 32'd1000;
        endcase
      end
      for (int i = 0; i < 7; i++) begin
        case ($urandom_range(0, 3))
          0, 1: sml[i] = 16'($urandom);
          2: sml[i] = sml_edge[$urandom_range(0, 4)];
          default: sml[i] = 16'($urandom_range(0, 2000)) - 16'd1000;
        endcase
      end
      send_frame(build_body(8'h00, 1'b1, c, t1, t2, ang, sml), 1'b0, '0);
      phase_bytes += FRAME_LEN + 1;
    end
    // a stray header among the junk can leave a frame open
    while (parse_open) send_byte(8'($urandom_range(0, 255)));
    settle();
  endtask

  initial begin
    frame_case_t  c;
    imu_reading_t given;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    // directed frames run with the command register at its reset value
    foreach (dir_cases[n]) begin
      c = dir_cases[n];
      for (int j = 0; j < c.junk_n; j++) send_byte(junk_pat[j]);
      given = '0;
      given.good = c.good;
      given.errs = c.errs;
      for (int i = 0; i < NUM_VALS; i++) given.val[i] = (i < 3) ? c.ang_q : c.sml_q;
      send_frame(build_body(c.fill, 1'b0, c.cmd, c.tail1, c.tail2, {3{c.ang}}, {7{c.sml}}),
                 c.typed, given);
    end
    settle();
    run_phase(8'hFF);
    run_phase(8'h00);
    run_phase(HEADER_BYTE);
    run_phase(8'($urandom_range(1, 254)));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // result side back-pressure, switching to a new random pattern when a countdown ends
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 4 != 0);
    endcase
  end

  always @(posedge clk) begin
    imu_reading_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_frame_good, out_error_count, out_quat_z, out_quat_y, out_quat_x, out_quat_w,
             out_rate_yaw, out_rate_roll, out_rate_pitch, out_yaw_deg, out_pitch_deg,
             out_roll_deg};
      if (want_q.size() == 0) begin
        report_mismatch("result with no frame pending", 32'(got.good), 32'h0);
      end else begin
        want = want_q.pop_front();
        if (got.good !== want.good) report_mismatch("frame_good", 32'(got.good), 32'(want.good));
        if (got.errs !== want.errs) report_mismatch("error_count", 32'(got.errs), 32'(want.errs));
        for (int i = 0; i < NUM_VALS; i++)
          if (got.val[i] !== want.val[i]) report_mismatch(val_name[i], got.val[i], want.val[i]);
      end
    end
  end

endmodule

@@ filelist.f @@
sv/iufp_pkg.sv
sv/iufp_frame_tracker.sv
sv/iufp_small_scaler.sv
sv/iufp_angle_scaler.sv
sv/imu_uart_frame_parser_core.sv
verif/tb.sv
